### hw/rtl/miou_pkg.sv
package miou_pkg;

   // accumulator, normaliser and step counter widths
   localparam int ACC_W  = 72;
   localparam int NRM_W  = 128;
   localparam int STEP_W = 8;

   localparam logic [15:0] BETA_RESET = 16'd4954;

   // scratch memory map
   localparam logic [4:0] RA_W   = 5'd0;
   localparam logic [4:0] RA_X   = 5'd1;
   localparam logic [4:0] RA_Y   = 5'd2;
   localparam logic [4:0] RA_Z   = 5'd3;
   localparam logic [4:0] RA_AX  = 5'd4;
   localparam logic [4:0] RA_AY  = 5'd5;
   localparam logic [4:0] RA_AZ  = 5'd6;
   localparam logic [4:0] RA_GX  = 5'd7;
   localparam logic [4:0] RA_GY  = 5'd8;
   localparam logic [4:0] RA_GZ  = 5'd9;
   localparam logic [4:0] RA_DT  = 5'd10;
   localparam logic [4:0] RA_F1  = 5'd11;
   localparam logic [4:0] RA_F2  = 5'd12;
   localparam logic [4:0] RA_F3  = 5'd13;
   localparam logic [4:0] RA_G1  = 5'd14;
   localparam logic [4:0] RA_G2  = 5'd15;
   localparam logic [4:0] RA_G3  = 5'd16;
   localparam logic [4:0] RA_G4  = 5'd17;
   localparam logic [4:0] RA_QN0 = 5'd18;
   localparam logic [4:0] RA_QN1 = 5'd19;
   localparam logic [4:0] RA_QN2 = 5'd20;
   localparam logic [4:0] RA_QN3 = 5'd21;
   localparam logic [4:0] RA_RL  = 5'd22;
   localparam logic [4:0] RA_RH  = 5'd23;

   // request field selectors for the load op
   localparam logic [5:0] FLD_ACCEL_X   = 6'd0;
   localparam logic [5:0] FLD_ACCEL_Y   = 6'd1;
   localparam logic [5:0] FLD_ACCEL_Z   = 6'd2;
   localparam logic [5:0] FLD_GYRO_X    = 6'd3;
   localparam logic [5:0] FLD_GYRO_Y    = 6'd4;
   localparam logic [5:0] FLD_GYRO_Z    = 6'd5;
   localparam logic [5:0] FLD_TIME_STEP = 6'd6;

   localparam logic [STEP_W-1:0] STEP_IDLE = 8'd6;

   typedef struct packed {
      logic [15:0]        time_step;
      logic signed [15:0] gyro_z;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_x;
      logic signed [15:0] accel_z;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_x;
   } req_item_type;

   typedef enum logic [3:0] {
      UOP_CLR,
      UOP_MAC,
      UOP_SHR,
      UOP_WSAT,
      UOP_WLO,
      UOP_LDIN,
      UOP_SLD,
      UOP_NRM,
      UOP_WAIT,
      UOP_EMIT,
      UOP_JMP
   } uop_type;

   typedef enum logic [1:0] {
      SRC_MEM,
      SRC_ONE,
      SRC_BETA
   } src_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD
   } phase_type;

   typedef struct packed {
      uop_type           uop;
      logic              clr;
      logic              sub;
      logic              keep;
      src_type           asel;
      src_type           bsel;
      logic [4:0]        ra;
      logic [4:0]        rb;
      logic [4:0]        wa;
      logic [5:0]        sh;
      logic [STEP_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic mul;
      logic acc;
      logic clr;
      logic shr;
      logic wsat;
      logic wlo;
      logic ldin;
      logic sld;
      logic nstart;
      logic nwrite;
   } dp_strobe_type;

   typedef struct packed {
      ucode_type     uw;
      dp_strobe_type stb;
   } dp_ctl_type;

   typedef struct packed {
      logic load_s;
      logic start;
   } nrm_ctl_type;

   typedef struct packed {
      logic ready;
      logic emit;
   } seq_stat_type;

   function automatic ucode_type uw_op(uop_type uop, logic [4:0] wa, logic [5:0] sh);
      ucode_type w;
      w        = '0;
      w.uop    = uop;
      w.asel   = SRC_MEM;
      w.bsel   = SRC_MEM;
      w.wa     = wa;
      w.sh     = sh;
      w.target = STEP_IDLE;
      return w;
   endfunction

   function automatic ucode_type uw_mac(logic clr, logic sub, src_type asel, logic [4:0] ra,
                                        src_type bsel, logic [4:0] rb, logic [5:0] sh);
      ucode_type w;
      w      = uw_op(UOP_MAC, RA_W, sh);
      w.clr  = clr;
      w.sub  = sub;
      w.asel = asel;
      w.bsel = bsel;
      w.ra   = ra;
      w.rb   = rb;
      return w;
   endfunction

   // plain product of two memory words
   function automatic ucode_type uw_mm(logic clr, logic sub, logic [4:0] ra, logic [4:0] rb,
                                       logic [5:0] sh);
      return uw_mac(clr, sub, SRC_MEM, ra, SRC_MEM, rb, sh);
   endfunction

   function automatic ucode_type uw_nrm(logic [4:0] ra, logic [4:0] wa, logic keep);
      ucode_type w;
      w      = uw_op(UOP_NRM, wa, 6'd0);
      w.ra   = ra;
      w.keep = keep;
      return w;
   endfunction

   // microprogram
   function automatic ucode_type ucode_word(logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         // reset: orientation to one
         8'd0:   w = uw_op(UOP_CLR, RA_W, 6'd0);
         8'd1:   w = uw_op(UOP_WSAT, RA_X, 6'd0);
         8'd2:   w = uw_op(UOP_WSAT, RA_Y, 6'd0);
         8'd3:   w = uw_op(UOP_WSAT, RA_Z, 6'd0);
         8'd4:   w = uw_mac(1'b1, 1'b0, SRC_ONE, RA_W, SRC_ONE, RA_W, 6'd30);
         8'd5:   w = uw_op(UOP_WSAT, RA_W, 6'd0);
         8'd6:   w = uw_op(UOP_WAIT, RA_W, 6'd0);
         // load request
         8'd7:   w = uw_op(UOP_LDIN, RA_AX, FLD_ACCEL_X);
         8'd8:   w = uw_op(UOP_LDIN, RA_AY, FLD_ACCEL_Y);
         8'd9:   w = uw_op(UOP_LDIN, RA_AZ, FLD_ACCEL_Z);
         8'd10:  w = uw_op(UOP_LDIN, RA_GX, FLD_GYRO_X);
         8'd11:  w = uw_op(UOP_LDIN, RA_GY, FLD_GYRO_Y);
         8'd12:  w = uw_op(UOP_LDIN, RA_GZ, FLD_GYRO_Z);
         8'd13:  w = uw_op(UOP_LDIN, RA_DT, FLD_TIME_STEP);
         // normalise accelerometer
         8'd14:  w = uw_mm(1'b1, 1'b0, RA_AX, RA_AX, 6'd0);
         8'd15:  w = uw_mm(1'b0, 1'b0, RA_AY, RA_AY, 6'd0);
         8'd16:  w = uw_mm(1'b0, 1'b0, RA_AZ, RA_AZ, 6'd0);
         8'd17:  w = uw_op(UOP_SLD, RA_W, 6'd0);
         8'd18:  w = uw_mm(1'b1, 1'b0, RA_AX, RA_AX, 6'd0);
         8'd19:  w = uw_nrm(RA_AX, RA_AX, 1'b0);
         8'd20:  w = uw_mm(1'b1, 1'b0, RA_AY, RA_AY, 6'd0);
         8'd21:  w = uw_nrm(RA_AY, RA_AY, 1'b0);
         8'd22:  w = uw_mm(1'b1, 1'b0, RA_AZ, RA_AZ, 6'd0);
         8'd23:  w = uw_nrm(RA_AZ, RA_AZ, 1'b0);
         // objective function
         8'd24:  w = uw_mm(1'b1, 1'b0, RA_X, RA_Z, 6'd0);
         8'd25:  w = uw_mm(1'b0, 1'b1, RA_W, RA_Y, 6'd0);
         8'd26:  w = uw_mac(1'b0, 1'b1, SRC_MEM, RA_AX, SRC_ONE, RA_W, 6'd29);
         8'd27:  w = uw_op(UOP_SHR, RA_W, 6'd30);
         8'd28:  w = uw_op(UOP_WSAT, RA_F1, 6'd0);
         8'd29:  w = uw_mm(1'b1, 1'b0, RA_W, RA_X, 6'd0);
         8'd30:  w = uw_mm(1'b0, 1'b0, RA_Y, RA_Z, 6'd0);
         8'd31:  w = uw_mac(1'b0, 1'b1, SRC_MEM, RA_AY, SRC_ONE, RA_W, 6'd29);
         8'd32:  w = uw_op(UOP_SHR, RA_W, 6'd30);
         8'd33:  w = uw_op(UOP_WSAT, RA_F2, 6'd0);
         8'd34:  w = uw_mac(1'b1, 1'b0, SRC_ONE, RA_W, SRC_ONE, RA_W, 6'd59);
         8'd35:  w = uw_mm(1'b0, 1'b1, RA_X, RA_X, 6'd0);
         8'd36:  w = uw_mm(1'b0, 1'b1, RA_Y, RA_Y, 6'd0);
         8'd37:  w = uw_mac(1'b0, 1'b1, SRC_MEM, RA_AZ, SRC_ONE, RA_W, 6'd29);
         8'd38:  w = uw_op(UOP_SHR, RA_W, 6'd30);
         8'd39:  w = uw_op(UOP_WSAT, RA_F3, 6'd0);
         // gradient halves
         8'd40:  w = uw_mm(1'b1, 1'b0, RA_X, RA_F2, 6'd0);
         8'd41:  w = uw_mm(1'b0, 1'b1, RA_Y, RA_F1, 6'd0);
         8'd42:  w = uw_op(UOP_SHR, RA_W, 6'd32);
         8'd43:  w = uw_op(UOP_WSAT, RA_G1, 6'd0);
         8'd44:  w = uw_mm(1'b1, 1'b0, RA_Z, RA_F1, 6'd0);
         8'd45:  w = uw_mm(1'b0, 1'b0, RA_W, RA_F2, 6'd0);
         8'd46:  w = uw_mm(1'b0, 1'b1, RA_X, RA_F3, 6'd1);
         8'd47:  w = uw_op(UOP_SHR, RA_W, 6'd32);
         8'd48:  w = uw_op(UOP_WSAT, RA_G2, 6'd0);
         8'd49:  w = uw_mm(1'b1, 1'b0, RA_Z, RA_F2, 6'd0);
         8'd50:  w = uw_mm(1'b0, 1'b1, RA_Y, RA_F3, 6'd1);
         8'd51:  w = uw_mm(1'b0, 1'b1, RA_W, RA_F1, 6'd0);
         8'd52:  w = uw_op(UOP_SHR, RA_W, 6'd32);
         8'd53:  w = uw_op(UOP_WSAT, RA_G3, 6'd0);
         8'd54:  w = uw_mm(1'b1, 1'b0, RA_X, RA_F1, 6'd0);
         8'd55:  w = uw_mm(1'b0, 1'b0, RA_Y, RA_F2, 6'd0);
         8'd56:  w = uw_op(UOP_SHR, RA_W, 6'd32);
         8'd57:  w = uw_op(UOP_WSAT, RA_G4, 6'd0);
         // normalise gradient
         8'd58:  w = uw_mm(1'b1, 1'b0, RA_G1, RA_G1, 6'd0);
         8'd59:  w = uw_mm(1'b0, 1'b0, RA_G2, RA_G2, 6'd0);
         8'd60:  w = uw_mm(1'b0, 1'b0, RA_G3, RA_G3, 6'd0);
         8'd61:  w = uw_mm(1'b0, 1'b0, RA_G4, RA_G4, 6'd0);
         8'd62:  w = uw_op(UOP_SLD, RA_W, 6'd0);
         8'd63:  w = uw_mm(1'b1, 1'b0, RA_G1, RA_G1, 6'd0);
         8'd64:  w = uw_nrm(RA_G1, RA_G1, 1'b0);
         8'd65:  w = uw_mm(1'b1, 1'b0, RA_G2, RA_G2, 6'd0);
         8'd66:  w = uw_nrm(RA_G2, RA_G2, 1'b0);
         8'd67:  w = uw_mm(1'b1, 1'b0, RA_G3, RA_G3, 6'd0);
         8'd68:  w = uw_nrm(RA_G3, RA_G3, 1'b0);
         8'd69:  w = uw_mm(1'b1, 1'b0, RA_G4, RA_G4, 6'd0);
         8'd70:  w = uw_nrm(RA_G4, RA_G4, 1'b0);
         // w component: -(x gx + y gy + z gz)
         8'd71:  w = uw_mm(1'b1, 1'b1, RA_X, RA_GX, 6'd4);
         8'd72:  w = uw_mm(1'b0, 1'b1, RA_Y, RA_GY, 6'd4);
         8'd73:  w = uw_mm(1'b0, 1'b1, RA_Z, RA_GZ, 6'd4);
         8'd74:  w = uw_mac(1'b0, 1'b1, SRC_MEM, RA_G1, SRC_BETA, RA_W, 6'd0);
         8'd75:  w = uw_op(UOP_SHR, RA_W, 6'd6);
         8'd76:  w = uw_op(UOP_WLO, RA_RL, 6'd0);
         8'd77:  w = uw_op(UOP_SHR, RA_W, 6'd16);
         8'd78:  w = uw_op(UOP_WSAT, RA_RH, 6'd0);
         8'd79:  w = uw_mm(1'b1, 1'b0, RA_RL, RA_DT, 6'd0);
         8'd80:  w = uw_mm(1'b0, 1'b0, RA_RH, RA_DT, 6'd16);
         8'd81:  w = uw_op(UOP_SHR, RA_W, 6'd30);
         8'd82:  w = uw_mac(1'b0, 1'b0, SRC_MEM, RA_W, SRC_ONE, RA_W, 6'd0);
         8'd83:  w = uw_op(UOP_WSAT, RA_QN0, 6'd0);
         // x component: w gx + y gz - z gy
         8'd84:  w = uw_mm(1'b1, 1'b0, RA_W, RA_GX, 6'd4);
         8'd85:  w = uw_mm(1'b0, 1'b0, RA_Y, RA_GZ, 6'd4);
         8'd86:  w = uw_mm(1'b0, 1'b1, RA_Z, RA_GY, 6'd4);
         8'd87:  w = uw_mac(1'b0, 1'b1, SRC_MEM, RA_G2, SRC_BETA, RA_W, 6'd0);
         8'd88:  w = uw_op(UOP_SHR, RA_W, 6'd6);
         8'd89:  w = uw_op(UOP_WLO, RA_RL, 6'd0);
         8'd90:  w = uw_op(UOP_SHR, RA_W, 6'd16);
         8'd91:  w = uw_op(UOP_WSAT, RA_RH, 6'd0);
         8'd92:  w = uw_mm(1'b1, 1'b0, RA_RL, RA_DT, 6'd0);
         8'd93:  w = uw_mm(1'b0, 1'b0, RA_RH, RA_DT, 6'd16);
         8'd94:  w = uw_op(UOP_SHR, RA_W, 6'd30);
         8'd95:  w = uw_mac(1'b0, 1'b0, SRC_MEM, RA_X, SRC_ONE, RA_W, 6'd0);
         8'd96:  w = uw_op(UOP_WSAT, RA_QN1, 6'd0);
         // y component: w gy - x gz + z gx
         8'd97:  w = uw_mm(1'b1, 1'b0, RA_W, RA_GY, 6'd4);
         8'd98:  w = uw_mm(1'b0, 1'b1, RA_X, RA_GZ, 6'd4);
         8'd99:  w = uw_mm(1'b0, 1'b0, RA_Z, RA_GX, 6'd4);
         8'd100: w = uw_mac(1'b0, 1'b1, SRC_MEM, RA_G3, SRC_BETA, RA_W, 6'd0);
         8'd101: w = uw_op(UOP_SHR, RA_W, 6'd6);
         8'd102: w = uw_op(UOP_WLO, RA_RL, 6'd0);
         8'd103: w = uw_op(UOP_SHR, RA_W, 6'd16);
         8'd104: w = uw_op(UOP_WSAT, RA_RH, 6'd0);
         8'd105: w = uw_mm(1'b1, 1'b0, RA_RL, RA_DT, 6'd0);
         8'd106: w = uw_mm(1'b0, 1'b0, RA_RH, RA_DT, 6'd16);
         8'd107: w = uw_op(UOP_SHR, RA_W, 6'd30);
         8'd108: w = uw_mac(1'b0, 1'b0, SRC_MEM, RA_Y, SRC_ONE, RA_W, 6'd0);
         8'd109: w = uw_op(UOP_WSAT, RA_QN2, 6'd0);
         // z component: w gz + x gy - y gx
         8'd110: w = uw_mm(1'b1, 1'b0, RA_W, RA_GZ, 6'd4);
         8'd111: w = uw_mm(1'b0, 1'b0, RA_X, RA_GY, 6'd4);
         8'd112: w = uw_mm(1'b0, 1'b1, RA_Y, RA_GX, 6'd4);
         8'd113: w = uw_mac(1'b0, 1'b1, SRC_MEM, RA_G4, SRC_BETA, RA_W, 6'd0);
         8'd114: w = uw_op(UOP_SHR, RA_W, 6'd6);
         8'd115: w = uw_op(UOP_WLO, RA_RL, 6'd0);
         8'd116: w = uw_op(UOP_SHR, RA_W, 6'd16);
         8'd117: w = uw_op(UOP_WSAT, RA_RH, 6'd0);
         8'd118: w = uw_mm(1'b1, 1'b0, RA_RL, RA_DT, 6'd0);
         8'd119: w = uw_mm(1'b0, 1'b0, RA_RH, RA_DT, 6'd16);
         8'd120: w = uw_op(UOP_SHR, RA_W, 6'd30);
         8'd121: w = uw_mac(1'b0, 1'b0, SRC_MEM, RA_Z, SRC_ONE, RA_W, 6'd0);
         8'd122: w = uw_op(UOP_WSAT, RA_QN3, 6'd0);
         // renormalise into the state and the result stage
         8'd123: w = uw_mm(1'b1, 1'b0, RA_QN0, RA_QN0, 6'd0);
         8'd124: w = uw_mm(1'b0, 1'b0, RA_QN1, RA_QN1, 6'd0);
         8'd125: w = uw_mm(1'b0, 1'b0, RA_QN2, RA_QN2, 6'd0);
         8'd126: w = uw_mm(1'b0, 1'b0, RA_QN3, RA_QN3, 6'd0);
         8'd127: w = uw_op(UOP_SLD, RA_W, 6'd0);
         8'd128: w = uw_mm(1'b1, 1'b0, RA_QN0, RA_QN0, 6'd0);
         8'd129: w = uw_nrm(RA_QN0, RA_W, 1'b1);
         8'd130: w = uw_mm(1'b1, 1'b0, RA_QN1, RA_QN1, 6'd0);
         8'd131: w = uw_nrm(RA_QN1, RA_X, 1'b1);
         8'd132: w = uw_mm(1'b1, 1'b0, RA_QN2, RA_QN2, 6'd0);
         8'd133: w = uw_nrm(RA_QN2, RA_Y, 1'b1);
         8'd134: w = uw_mm(1'b1, 1'b0, RA_QN3, RA_QN3, 6'd0);
         8'd135: w = uw_nrm(RA_QN3, RA_Z, 1'b1);
         8'd136: w = uw_op(UOP_EMIT, RA_W, 6'd0);
         default: w = uw_op(UOP_JMP, RA_W, 6'd0);
      endcase
      return w;
   endfunction

endpackage

### hw/rtl/miou_norm.sv
// bit-serial exact normaliser: largest u with u^2 * s <= a^2 * 2^60
module miou_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  miou_pkg::nrm_ctl_type ctl,
   input  logic [63:0]           sum_sq,
   input  logic [61:0]           comp_sq,
   output logic                  busy,
   output logic [30:0]           result
);

   logic [63:0]              s_ff;
   logic [miou_pkg::NRM_W-1:0] p_ff, v_ff, s2_ff, lim_ff;
   logic [miou_pkg::NRM_W-1:0] trial;
   logic [30:0]              u_ff;
   logic [4:0]               bit_ff;
   logic                     run_ff;
   logic                     take;

   // trial = (u + 2^b)^2 * s kept as running partial terms
   assign trial = p_ff + v_ff + s2_ff;
   assign take  = (trial <= lim_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (ctl.start) begin
         run_ff <= 1'b1;
      end else if (run_ff && bit_ff == 5'd0) begin
         run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s) begin
         s_ff <= sum_sq;
      end
      if (ctl.start) begin
         p_ff   <= '0;
         v_ff   <= '0;
         s2_ff  <= {4'b0, s_ff, 60'b0};
         lim_ff <= {6'b0, comp_sq, 60'b0};
         u_ff   <= '0;
         bit_ff <= 5'd30;
      end else if (run_ff) begin
         if (take) begin
            p_ff         <= trial;
            v_ff         <= (v_ff >> 1) + s2_ff;
            u_ff[bit_ff] <= 1'b1;
         end else begin
            v_ff <= v_ff >> 1;
         end
         s2_ff  <= s2_ff >> 2;
         bit_ff <= bit_ff - 5'd1;
      end
   end

   assign busy   = run_ff;
   assign result = (s_ff == 64'd0) ? 31'd0 : u_ff;

endmodule

### hw/rtl/miou_dpath.sv
// scratch memory, shared multiplier, accumulator and result stage
module miou_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  miou_pkg::dp_ctl_type   ctl,
   input  miou_pkg::req_item_type item,
   input  logic [15:0]            beta,
   output logic                   norm_busy,
   output logic [3:0][31:0]       stage
);

   localparam logic signed [miou_pkg::ACC_W-1:0] SAT_POS = 72'sd2147483647;
   localparam logic signed [miou_pkg::ACC_W-1:0] SAT_NEG = -72'sd2147483647;

   miou_pkg::ucode_type uw;

   logic signed [31:0] mem [32];
   logic signed [31:0] rda_ff, rdb_ff;
   logic signed [31:0] opa, opb;
   logic signed [63:0] prod_ff;
   logic signed [miou_pkg::ACC_W-1:0] acc_ff, acc_in, prod_ext, base;
   logic signed [31:0] sat_val, ld_val, nrm_val, wr_data;
   logic               wr_en;
   logic [30:0]        nrm_u;
   logic [3:0][31:0]   stage_ff;
   miou_pkg::nrm_ctl_type nctl;

   assign uw = ctl.uw;

   always_comb begin
      opa = (uw.asel == miou_pkg::SRC_ONE) ? 32'sd1 : rda_ff;
      case (uw.bsel)
         miou_pkg::SRC_ONE:  opb = 32'sd1;
         miou_pkg::SRC_BETA: opb = $signed({16'b0, beta});
         default:            opb = rdb_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.stb.mul) begin
         prod_ff <= opa * opb;
      end
   end

   assign prod_ext = {{(miou_pkg::ACC_W-64){prod_ff[63]}}, prod_ff} <<< uw.sh;
   assign base     = uw.clr ? '0 : acc_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.stb.clr) begin
         acc_in = '0;
      end else if (ctl.stb.acc) begin
         acc_in = uw.sub ? base - prod_ext : base + prod_ext;
      end else if (ctl.stb.shr) begin
         acc_in = acc_ff >>> uw.sh;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_comb begin
      if (acc_ff > SAT_POS) begin
         sat_val = 32'sh7fffffff;
      end else if (acc_ff < SAT_NEG) begin
         sat_val = -32'sh7fffffff;
      end else begin
         sat_val = acc_ff[31:0];
      end
   end

   always_comb begin
      case (uw.sh)
         miou_pkg::FLD_ACCEL_X:   ld_val = 32'(item.accel_x);
         miou_pkg::FLD_ACCEL_Y:   ld_val = 32'(item.accel_y);
         miou_pkg::FLD_ACCEL_Z:   ld_val = 32'(item.accel_z);
         miou_pkg::FLD_GYRO_X:    ld_val = 32'(item.gyro_x);
         miou_pkg::FLD_GYRO_Y:    ld_val = 32'(item.gyro_y);
         miou_pkg::FLD_GYRO_Z:    ld_val = 32'(item.gyro_z);
         miou_pkg::FLD_TIME_STEP: ld_val = $signed({16'b0, item.time_step});
         default:                 ld_val = '0;
      endcase
   end

   // sign comes from the source word read at ra
   assign nrm_val = rda_ff[31] ? -$signed({1'b0, nrm_u}) : $signed({1'b0, nrm_u});

   always_comb begin
      wr_en   = ctl.stb.wsat | ctl.stb.wlo | ctl.stb.ldin | ctl.stb.nwrite;
      wr_data = sat_val;
      if (ctl.stb.wlo) begin
         wr_data = $signed({16'b0, acc_ff[15:0]});
      end else if (ctl.stb.ldin) begin
         wr_data = ld_val;
      end else if (ctl.stb.nwrite) begin
         wr_data = nrm_val;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[uw.wa] <= wr_data;
      end
      rda_ff <= mem[uw.ra];
      rdb_ff <= mem[uw.rb];
   end

   always_ff @(posedge clock) begin
      if (ctl.stb.nwrite && uw.keep) begin
         stage_ff[uw.wa[1:0]] <= nrm_val;
      end
   end

   assign nctl.load_s = ctl.stb.sld;
   assign nctl.start  = ctl.stb.nstart;

   miou_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .ctl     (nctl),
      .sum_sq  (acc_ff[63:0]),
      .comp_sq (acc_ff[61:0]),
      .busy    (norm_busy),
      .result  (nrm_u)
   );

   assign stage = stage_ff;

endmodule

### hw/rtl/miou_seq.sv
// step counter and microcode decode
module miou_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   out_free,
   input  logic                   norm_busy,
   output miou_pkg::dp_ctl_type   dp_ctl,
   output miou_pkg::seq_stat_type stat
);

   logic [miou_pkg::STEP_W-1:0] step_ff, step_in;
   miou_pkg::phase_type         phase_ff, phase_in;
   miou_pkg::ucode_type         uw;
   miou_pkg::dp_strobe_type     stb;

   assign uw = miou_pkg::ucode_word(step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         phase_ff <= miou_pkg::PH_FIRST;
      end else begin
         step_ff  <= step_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      logic adv;
      adv        = 1'b0;
      step_in    = step_ff;
      phase_in   = phase_ff;
      stb        = '0;
      stat.ready = 1'b0;
      stat.emit  = 1'b0;
      unique case (uw.uop)
         miou_pkg::UOP_CLR: begin
            stb.clr = 1'b1;
            adv     = 1'b1;
         end
         miou_pkg::UOP_MAC: begin
            unique case (phase_ff)
               miou_pkg::PH_FIRST:  phase_in = miou_pkg::PH_SECOND;
               miou_pkg::PH_SECOND: begin
                  stb.mul  = 1'b1;
                  phase_in = miou_pkg::PH_THIRD;
               end
               default: begin
                  stb.acc = 1'b1;
                  adv     = 1'b1;
               end
            endcase
         end
         miou_pkg::UOP_SHR: begin
            stb.shr = 1'b1;
            adv     = 1'b1;
         end
         miou_pkg::UOP_WSAT: begin
            stb.wsat = 1'b1;
            adv      = 1'b1;
         end
         miou_pkg::UOP_WLO: begin
            stb.wlo = 1'b1;
            adv     = 1'b1;
         end
         miou_pkg::UOP_LDIN: begin
            stb.ldin = 1'b1;
            adv      = 1'b1;
         end
         miou_pkg::UOP_SLD: begin
            stb.sld = 1'b1;
            adv     = 1'b1;
         end
         miou_pkg::UOP_NRM: begin
            if (phase_ff == miou_pkg::PH_FIRST) begin
               stb.nstart = 1'b1;
               phase_in   = miou_pkg::PH_SECOND;
            end else if (!norm_busy) begin
               stb.nwrite = 1'b1;
               adv        = 1'b1;
            end
         end
         miou_pkg::UOP_WAIT: begin
            stat.ready = 1'b1;
            adv        = req_valid;
         end
         miou_pkg::UOP_EMIT: begin
            stat.emit = out_free;
            adv       = out_free;
         end
         default: begin
            step_in = uw.target;
         end
      endcase
      if (adv) begin
         step_in  = miou_pkg::STEP_W'(step_ff + 1'b1);
         phase_in = miou_pkg::PH_FIRST;
      end
   end

   assign dp_ctl.uw  = uw;
   assign dp_ctl.stb = stb;

endmodule

### hw/rtl/madgwick_imu_orientation_update_unit.sv
// madgwick 6-axis orientation update, one gradient-descent step per request
//
// req channel: one imu sample per request (accel, gyro in rad/s * 2^11,
// time step in s * 2^20). rsp channel: the updated quaternion in q1.30,
// which is also kept as the filter state for the next request.
// csr port: beta gain * 2^16, written whenever csr_wr_en is high.
//
// a microcoded sequencer drives one 32x32 multiplier with a 72-bit
// accumulator and a bit-serial normaliser over a small scratch memory.
// one request runs through seventy multiply-accumulate steps, eleven
// normalisations and forty-nine other steps, from the load of the
// sample to the emit. a new request is taken only after the result of
// the last one has moved to the output register, so the block does not
// work on two requests at once.
//
// reset: beta returns to its default, and the reset steps return the state
// to the unit quaternion before req_tready first rises.
// a stalled receiver holds rsp_tdata; the block still accepts and works on
// the next request and waits only when that result is ready to go out.
module madgwick_imu_orientation_update_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_step
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // quat_w_out, quat_x_out, quat_y_out, quat_z_out
   output logic [127:0] rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   miou_pkg::dp_ctl_type   dp_ctl;
   miou_pkg::seq_stat_type stat;
   miou_pkg::req_item_type item_ff;

   logic [15:0]      beta_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [127:0]     rsp_data_ff;
   logic [3:0][31:0] stage;
   logic             norm_busy;
   logic             out_free;
   logic             req_accept;

   assign req_accept = req_tvalid & stat.ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // beta gain register
   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff <= miou_pkg::BETA_RESET;
      end else if (csr_wr_en) begin
         beta_ff <= csr_wr_data;
      end
   end

   // request capture, read out field by field by the load steps
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= miou_pkg::req_item_type'(req_tdata);
      end
   end

   miou_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .norm_busy (norm_busy),
      .dp_ctl    (dp_ctl),
      .stat      (stat)
   );

   miou_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dp_ctl),
      .item      (item_ff),
      .beta      (beta_ff),
      .norm_busy (norm_busy),
      .stage     (stage)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stat.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.emit) begin
         rsp_data_ff <= stage;
      end
   end

   assign req_tready = stat.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a result never overwrites one still waiting at the output
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      stat.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result emitted over a pending response");

   // a request is only taken with the normaliser idle
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !norm_busy)
      else $error("request accepted while normaliser busy");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // emitting and waiting for a request never happen in the same step
   a_emit_not_ready: assert property (@(posedge clock) disable iff (reset)
      stat.emit |-> !req_tready)
      else $error("emit and request wait in the same step");

endmodule

### dv/madgwick_imu_orientation_update_unit_tb.sv
module madgwick_imu_orientation_update_unit_tb;

   // one quaternion, w first
   typedef struct packed {
      logic signed [31:0] qz;
      logic signed [31:0] qy;
      logic signed [31:0] qx;
      logic signed [31:0] qw;
   } quat_type;

   // directed row: sample, and where obvious the quaternion that must come back
   typedef struct {
      miou_pkg::req_item_type smp;
      bit                     known;
      quat_type               quat;
   } sample_row_type;

   localparam longint SAT_MAX     = 64'sd2147483647;
   localparam int     ONE_Q30     = 32'sd1073741824;
   localparam int     IDLE_LIMIT  = 20000;
   localparam int     LONG_HOLD   = 3000;
   localparam int     RANDOM_ITEMS = 1200;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_step
   logic [111:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // quat_w_out, quat_x_out, quat_y_out, quat_z_out
   logic [127:0] rsp_tdata;
   logic         csr_wr_en;
   logic [15:0]  csr_wr_data;

   // predictor copy of the filter state and the gain
   longint       orient_q[4];
   longint       beta_model;
   quat_type     quat_expected_q[$];
   int           mismatch_count;
   int           idle_cycles;
   bit           hold_rsp_request;
   bit           gapless;

   madgwick_imu_orientation_update_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint clip32(longint v);
      if (v > SAT_MAX) return SAT_MAX;
      if (v < -SAT_MAX) return -SAT_MAX;
      return v;
   endfunction

   // exact unit vector in q1.30, truncated toward zero; zero length gives zero
   function automatic void unit_vector(input longint v[4], input int n, output longint o[4]);
      logic [63:0]  len2;
      logic [63:0]  mag;
      logic [63:0]  root;
      logic [63:0]  trial;
      logic [127:0] bound;
      logic [127:0] lhs;
      len2 = '0;
      for (int i = 0; i < 4; i++) o[i] = 0;
      for (int i = 0; i < n; i++) begin
         mag  = (v[i] < 0) ? -v[i] : v[i];
         len2 = len2 + mag * mag;
      end
      if (len2 == 0) return;
      for (int i = 0; i < n; i++) begin
         mag   = (v[i] < 0) ? -v[i] : v[i];
         bound = 128'(mag * mag) << 60;
         root  = '0;
         for (int b = 30; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            lhs   = 128'(trial * trial) * 128'(len2);
            if (lhs <= bound) root = trial;
         end
         o[i] = (v[i] < 0) ? -longint'(root) : longint'(root);
      end
   endfunction

   // one gradient-descent step; updates the predicted state
   function automatic quat_type orientation_step(miou_pkg::req_item_type s);
      longint acc[4], an[4], grad[4], gn[4], qsum[4], qo[4], rate[4];
      longint w, x, y, z, gx, gy, gz, dt, half, f1, f2, f3, r40;
      quat_type res;
      w = orient_q[0]; x = orient_q[1]; y = orient_q[2]; z = orient_q[3];
      gx = longint'(s.gyro_x); gy = longint'(s.gyro_y); gz = longint'(s.gyro_z);
      dt = longint'({48'd0, s.time_step});
      half = 64'sd1 << 29;
      acc[0] = longint'(s.accel_x); acc[1] = longint'(s.accel_y);
      acc[2] = longint'(s.accel_z); acc[3] = 0;
      unit_vector(acc, 3, an);
      f1 = clip32((x * z - w * y - an[0] * half) >>> 30);
      f2 = clip32((w * x + y * z - an[1] * half) >>> 30);
      f3 = clip32(((64'sd1 << 59) - x * x - y * y - an[2] * half) >>> 30);
      grad[0] = clip32((x * f2 - y * f1) >>> 32);
      grad[1] = clip32((z * f1 + w * f2 - 2 * x * f3) >>> 32);
      grad[2] = clip32((z * f2 - 2 * y * f3 - w * f1) >>> 32);
      grad[3] = clip32((x * f1 + y * f2) >>> 32);
      unit_vector(grad, 4, gn);
      // gyro quaternion rate, q (x) (0, gx, gy, gz)
      rate[0] = -(x * gx + y * gy + z * gz);
      rate[1] = w * gx + y * gz - z * gy;
      rate[2] = w * gy - x * gz + z * gx;
      rate[3] = w * gz + x * gy - y * gx;
      for (int k = 0; k < 4; k++) begin
         r40     = (rate[k] * 16 - beta_model * gn[k]) >>> 6;
         qsum[k] = clip32(orient_q[k] + ((r40 * dt) >>> 30));
      end
      unit_vector(qsum, 4, qo);
      for (int k = 0; k < 4; k++) orient_q[k] = qo[k];
      res.qw = 32'(qo[0]); res.qx = 32'(qo[1]); res.qy = 32'(qo[2]); res.qz = 32'(qo[3]);
      return res;
   endfunction

   function automatic int idle_draw();
      return gapless ? 0 : $urandom_range(8, 0);
   endfunction

   // offer one request, wait for it to go in, then log its expectation
   task automatic send_sample(miou_pkg::req_item_type s, bit known, quat_type quat);
      quat_type pred;
      repeat (idle_draw()) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = s;
      do @(posedge clock); while (!req_tready);
      pred = orientation_step(s);
      quat_expected_q.push_back(known ? quat : pred);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // gain write, only with nothing in flight
   task automatic write_beta(logic [15:0] gain);
      wait (quat_expected_q.size() == 0);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = gain;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      beta_model  = gain;
   endtask

   function automatic miou_pkg::req_item_type random_sample();
      miou_pkg::req_item_type s;
      int mode;
      mode = $urandom_range(9, 0);
      s = miou_pkg::req_item_type'(112'({$urandom, $urandom, $urandom, $urandom}));
      // mostly modest rates and time steps so the state moves smoothly
      if (mode < 6) begin
         s.gyro_x    = $signed(16'($urandom_range(4096, 0))) - 16'sd2048;
         s.gyro_y    = $signed(16'($urandom_range(4096, 0))) - 16'sd2048;
         s.gyro_z    = $signed(16'($urandom_range(4096, 0))) - 16'sd2048;
         s.time_step = 16'($urandom_range(4000, 0));
      end
      if (mode == 6) begin
         s.accel_x = '0; s.accel_y = '0; s.accel_z = '0;
      end
      if (mode == 7) s.time_step = '0;
      return s;
   endfunction

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp_request) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp_request = 1'b0;
         end
         gap = idle_draw();
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // compare every accepted result against the oldest expectation
   always @(posedge clock) begin
      quat_type got;
      quat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (quat_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result %h", rsp_tdata);
         end else begin
            want = quat_expected_q.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp w %0d x %0d y %0d z %0d, got w %0d x %0d y %0d z %0d",
                           want.qw, want.qx, want.qy, want.qz,
                           got.qw, got.qx, got.qy, got.qz);
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      sample_row_type rows[$];
      sample_row_type r;
      quat_type unit_q;
      quat_type none_q;
      logic [15:0] gains[4];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      mismatch_count = 0;
      idle_cycles = 0;
      hold_rsp_request = 1'b0;
      gapless = 1'b0;
      orient_q = '{64'sd1 << 30, 0, 0, 0};
      beta_model = miou_pkg::BETA_RESET;
      unit_q = '{qz: 0, qy: 0, qx: 0, qw: ONE_Q30};
      none_q = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows; zero time step from the unit quaternion keeps it unit
      r.known = 1'b1; r.quat = unit_q;
      r.smp = '{16'd0, 16'sh7fff, -16'sd32768, 16'sh7fff, -16'sd32768, 16'sh7fff, -16'sd32768};
      rows.push_back(r);
      // zero accel and zero gyro: gradient zero, no rate, stays unit
      r.smp = '{16'hffff, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
      rows.push_back(r);
      r.known = 1'b0; r.quat = none_q;
      r.smp = '{16'd1000, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
      rows.push_back(r);
      r.smp = '{16'd1000, 16'sd2048, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
      rows.push_back(r);
      r.smp = '{16'd4000, -16'sd2048, 16'sd1024, 16'sd512, 16'sd100, -16'sd300, 16'sd16000};
      rows.push_back(r);
      r.smp = '{16'hffff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
      rows.push_back(r);
      r.smp = '{16'hffff, -16'sd32768, -16'sd32768, -16'sd32768,
                -16'sd32768, -16'sd32768, -16'sd32768};
      rows.push_back(r);
      r.smp = '{16'd0, 16'sd5, -16'sd5, 16'sd5, 16'sd1, 16'sd1, 16'sd1};
      rows.push_back(r);
      r.smp = '{16'd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0};
      rows.push_back(r);
      r.smp = '{16'h8000, 16'sd1, 16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0};
      rows.push_back(r);
      r.smp = '{16'd2000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0};
      rows.push_back(r);
      r.smp = '{16'd2000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384};
      rows.push_back(r);
      foreach (rows[i]) send_sample(rows[i].smp, rows[i].known, rows[i].quat);

      // gain extremes, a random one, then back to the default
      gains = '{16'd0, 16'hffff, 16'($urandom_range(65535, 0)), miou_pkg::BETA_RESET};
      for (int p = 0; p < 4; p++) begin
         write_beta(gains[p]);
         gapless = (p == 2);
         for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
            if (p == 1 && i == 10) hold_rsp_request = 1'b1;
            send_sample(random_sample(), 1'b0, none_q);
         end
         gapless = 1'b0;
         // pause the sender until the pipe has drained
         wait (quat_expected_q.size() == 0);
      end

      wait (quat_expected_q.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
